// ----- rtl/fcpa_pkg.sv -----
// fcpa_pkg: shared types, constants and status codes for the chunk pool allocator
// used by every module under rtl/ except fcpa_ram; depends on nothing else
`default_nettype none

package fcpa_pkg;

  // free ring and fresh counter
  localparam int RING_DEPTH  = 4096;
  localparam int CHUNK_LIMIT = 4095;
  localparam int SLOT_W      = $clog2(RING_DEPTH);
  localparam int PTR_W       = $clog2(2 * RING_DEPTH);
  localparam int PTR_SPAN    = 2 * RING_DEPTH;

  // field widths
  localparam int IDX_W    = 12;
  localparam int CB_W     = 17;
  localparam int ADDR_W   = 48;
  localparam int PROD_W   = IDX_W + CB_W;
  localparam int CFG_IDX_W = 8;

  // job queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = CFG_IDX_W'(1);

  localparam logic [CB_W-1:0]   CHUNK_BYTES_RESET  = CB_W'(512);
  localparam logic [ADDR_W-1:0] BASE_ADDRESS_RESET = '0;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_QUEUE_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] freed_index;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  chunk_index;
    logic [ADDR_W-1:0] chunk_address;
  } rsp_t;

  // classified request on its way to the back end
  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] chunk_index;
    logic             addr_en;
  } job_t;

endpackage

`default_nettype wire

// ----- rtl/fcpa_ram.sv -----
// fcpa_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module fcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fcpa_front.sv -----
// fcpa_front: takes requests, classifies them against the free ring and fresh counter
// holds the free ring memory (fcpa_ram); uses fcpa_pkg
`default_nettype none

module fcpa_front import fcpa_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire req_t            req,
  input  wire logic [Q_CW-1:0] q_count,
  output logic                 q_push,
  output job_t                 q_job
);

  logic [PTR_W-1:0] pop_pointer;
  logic [PTR_W-1:0] push_pointer;
  logic [IDX_W-1:0] next_fresh;

  logic             s1_valid;
  status_t          s1_status;
  logic [IDX_W-1:0] s1_index;
  logic             s1_from_ram;
  logic             s1_addr_en;

  logic [PTR_W:0]   fill_wide;
  logic [PTR_W-1:0] fill;
  logic             ring_empty;
  logic             ring_full;
  logic             fresh_left;
  logic             acc;
  logic             alloc_pop;
  logic             alloc_fresh;
  logic             free_ok;
  logic [IDX_W-1:0] ram_rdata;

  function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(PTR_SPAN - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    if (p >= PTR_W'(RING_DEPTH)) begin
      s = p - PTR_W'(RING_DEPTH);
    end else begin
      s = p;
    end
    return s[SLOT_W-1:0];
  endfunction

  // fill level, pointers counted modulo twice the ring depth
  always_comb begin
    fill_wide = {1'b0, push_pointer} + (PTR_W + 1)'(PTR_SPAN) - {1'b0, pop_pointer};
    if (fill_wide >= (PTR_W + 1)'(PTR_SPAN)) begin
      fill_wide = fill_wide - (PTR_W + 1)'(PTR_SPAN);
    end
    fill = fill_wide[PTR_W-1:0];
  end

  assign ring_empty = (fill == '0);
  assign ring_full  = (fill >= PTR_W'(RING_DEPTH));
  assign fresh_left = (32'(next_fresh) < 32'(CHUNK_LIMIT));

  // room for this request plus the one already in flight
  assign req_stall = ((32'(q_count) + 32'(s1_valid)) >= 32'(Q_DEPTH));
  assign acc       = req_valid && !req_stall;

  assign alloc_pop   = !req.mode && !ring_empty;
  assign alloc_fresh = !req.mode && ring_empty && fresh_left;
  assign free_ok     = req.mode && !ring_full;

  fcpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (acc && free_ok),
    .wr_addr (slot_of(push_pointer)),
    .wr_data (req.freed_index),
    .rd_en   (acc && alloc_pop),
    .rd_addr (slot_of(pop_pointer)),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_pointer  <= '0;
      push_pointer <= '0;
      next_fresh   <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= acc;
      if (acc && alloc_pop) begin
        pop_pointer <= ring_advance(pop_pointer);
      end
      if (acc && alloc_fresh) begin
        next_fresh <= next_fresh + 1'b1;
      end
      if (acc && free_ok) begin
        push_pointer <= ring_advance(push_pointer);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_from_ram <= alloc_pop;
      s1_addr_en  <= alloc_pop || alloc_fresh;
      if (req.mode) begin
        s1_status <= ring_full ? ST_QUEUE_FULL : ST_OK;
        s1_index  <= req.freed_index;
      end else if (alloc_pop || alloc_fresh) begin
        s1_status <= ST_OK;
        s1_index  <= next_fresh;
      end else begin
        s1_status <= ST_EXHAUSTED;
        s1_index  <= '0;
      end
    end
  end

  // popped index arrives from the ring in the cycle after the read
  assign q_push = s1_valid;
  always_comb begin
    q_job.status      = s1_status;
    q_job.chunk_index = s1_from_ram ? ram_rdata : s1_index;
    q_job.addr_en     = s1_addr_en;
  end

endmodule

`default_nettype wire

// ----- rtl/fcpa_queue.sv -----
// fcpa_queue: short job queue decoupling the front end from the back end
// uses fcpa_pkg (job_t, queue depth)
`default_nettype none

module fcpa_queue import fcpa_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire job_t            push_job,
  input  wire logic            pop,
  output logic                 head_valid,
  output job_t                 head_job,
  output logic [Q_CW-1:0]      count
);

  job_t            entry [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;

  assign head_valid = (count != '0);
  assign head_job   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fcpa_back.sv -----
// fcpa_back: configuration registers and address generation, base + index * chunk size
// two stages: multiply, then add into the response register; uses fcpa_pkg
`default_nettype none

module fcpa_back import fcpa_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data,
  input  wire logic                 q_valid,
  input  wire job_t                 q_job,
  output logic                      q_pop,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output rsp_t                      rsp
);

  logic [CB_W-1:0]   chunk_bytes;
  logic [ADDR_W-1:0] base_address;

  logic              a_valid;
  status_t           a_status;
  logic [IDX_W-1:0]  a_index;
  logic              a_addr_en;
  logic [PROD_W-1:0] a_prod;

  logic              adv_out;
  logic              adv_a;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes  <= CHUNK_BYTES_RESET;
      base_address <= BASE_ADDRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHUNK_BYTES:  chunk_bytes  <= cfg_data[CB_W-1:0];
        CFG_BASE_ADDRESS: base_address <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign adv_out = !rsp_valid || !rsp_stall;
  assign adv_a   = !a_valid || adv_out;
  assign q_pop   = q_valid && adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid <= q_valid;
      end
      if (adv_out) begin
        rsp_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_status  <= q_job.status;
      a_index   <= q_job.chunk_index;
      a_addr_en <= q_job.addr_en;
      a_prod    <= PROD_W'(q_job.chunk_index) * PROD_W'(chunk_bytes);
    end
    if (adv_out && a_valid) begin
      rsp.status        <= a_status;
      rsp.chunk_index   <= a_index;
      // sum wraps at the address width
      rsp.chunk_address <= a_addr_en ? (base_address + ADDR_W'(a_prod)) : '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fixed_chunk_pool_allocator.sv -----
// fixed_chunk_pool_allocator: top level of the fixed-size chunk pool allocator
// instantiates fcpa_front, fcpa_queue and fcpa_back; uses fcpa_pkg
//
//   channel | signals                                  | payload
//   --------+------------------------------------------+------------------------------
//   req     | req_valid / req_stall                    | req_t: mode, freed_index
//   rsp     | rsp_valid / rsp_stall                    | rsp_t: status, index, address
//   cfg     | cfg_valid / cfg_ready, cfg_index         | cfg_data (48 bits)
//
// one request per cycle sustained while rsp_stall stays low; a request passes the ring read,
// queue, multiply and add; at most one ring access and one multiply-add per request
// rst is synchronous: pointers, fresh counter and pipeline valids clear, registers take
// reset values; the ring memory is not cleared, entries are always written before read
// a response stall fills the job queue; req_stall rises when full, counting the s1 job
`default_nettype none

module fixed_chunk_pool_allocator import fcpa_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire req_t                 req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output rsp_t                      rsp,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data
);

  logic            q_push;
  job_t            q_push_job;
  logic            q_pop;
  logic            q_head_valid;
  job_t            q_head_job;
  logic [Q_CW-1:0] q_count;

  fcpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_job     (q_push_job)
  );

  fcpa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_push_job),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .count      (q_count)
  );

  fcpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_head_valid),
    .q_job     (q_head_job),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ----- rtl/fcpa_checker.sv -----
// fcpa_checker: port-level assertions for fixed_chunk_pool_allocator, bound to the top
// uses fcpa_pkg
`default_nettype none

module fcpa_checker import fcpa_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  // a stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // reset empties the response register
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // only a successful allocate carries an address
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_EXHAUSTED || rsp.status == ST_QUEUE_FULL)
      |-> rsp.chunk_address == '0)
    else $error("address on failed request");

  // exhaustion reports index zero
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_EXHAUSTED |-> rsp.chunk_index == '0)
    else $error("index on exhausted allocate");

endmodule

bind fixed_chunk_pool_allocator fcpa_checker u_fcpa_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

// ----- verif/fixed_chunk_pool_allocator_tb.sv -----
// fixed_chunk_pool_allocator_tb: self-checking testbench for the chunk pool allocator
// drives requests and register writes and predicts every response in a scoreboard class
// depends on fcpa_pkg and fixed_chunk_pool_allocator

module fixed_chunk_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcpa_pkg::*;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_NEXT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP  = '1;

  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  // free ring, fresh counter and register copies; one expected response per request
  class pool_ledger;
    logic [IDX_W-1:0]  ring [RING_DEPTH];
    logic [PTR_W-1:0]  pop_ptr;
    logic [PTR_W-1:0]  push_ptr;
    int unsigned       next_fresh;
    logic [CB_W-1:0]   chunk_bytes;
    logic [ADDR_W-1:0] base_address;
    rsp_t              expected_q[$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       ok_count;
    int unsigned       exhausted_count;
    int unsigned       rejected_count;

    function new();
      pop_ptr         = '0;
      push_ptr        = '0;
      next_fresh      = 0;
      chunk_bytes     = CHUNK_BYTES_RESET;
      base_address    = BASE_ADDRESS_RESET;
      mismatches      = 0;
      checked         = 0;
      ok_count        = 0;
      exhausted_count = 0;
      rejected_count  = 0;
    endfunction

    // pointers run modulo twice the depth, so the 13-bit difference is the fill level
    function logic [PTR_W-1:0] fill();
      return push_ptr - pop_ptr;
    endfunction

    function bit ring_full();
      return fill() >= RING_DEPTH;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      if (idx == CFG_CHUNK_BYTES) begin
        chunk_bytes = data[CB_W-1:0];
      end else if (idx == CFG_BASE_ADDRESS) begin
        base_address = data;
      end
    endfunction

    function rsp_t note_request(req_t r);
      rsp_t              want;
      logic [ADDR_W-1:0] offset;
      want = '0;
      want.status = ST_OK;
      if (r.mode == MODE_ALLOC) begin
        if (fill() != 0) begin
          want.chunk_index = ring[pop_ptr[SLOT_W-1:0]];
          pop_ptr++;
        end else if (next_fresh >= CHUNK_LIMIT) begin
          want.status = ST_EXHAUSTED;
        end else begin
          want.chunk_index = IDX_W'(next_fresh);
          next_fresh++;
        end
        if (want.status == ST_OK) begin
          // 48-bit context: the product and the sum wrap at 2^48
          offset = want.chunk_index * chunk_bytes;
          want.chunk_address = base_address + offset;
        end
      end else begin
        want.chunk_index = r.freed_index;
        if (ring_full()) begin
          want.status = ST_QUEUE_FULL;
        end else begin
          ring[push_ptr[SLOT_W-1:0]] = r.freed_index;
          push_ptr++;
        end
      end
      case (want.status)
        ST_OK:        ok_count++;
        ST_EXHAUSTED: exhausted_count++;
        default:      rejected_count++;
      endcase
      expected_q.push_back(want);
      return want;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] mismatch: %s", $realtime, what);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("response with none outstanding: status %0d index %h address %h",
                       got.status, got.chunk_index, got.chunk_address));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.status !== want.status || got.chunk_index !== want.chunk_index ||
          got.chunk_address !== want.chunk_address) begin
        flag($sformatf({"response %0d: expected status %0d index %h address %h, ",
                        "got status %0d index %h address %h"},
                       checked, want.status, want.chunk_index, want.chunk_address,
                       got.status, got.chunk_index, got.chunk_address));
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req       = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data  = '0;

  pool_ledger       ledger;
  logic [IDX_W-1:0] live[$];      // indices handed out and not yet freed
  bit               calm     = 1'b0;
  int unsigned      hold_cnt = 0;
  int unsigned      sent     = 0;
  int unsigned      settings = 0;

  always #6 clk = ~clk;

  fixed_chunk_pool_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mostly none or short, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // response side: check each transfer, then decide the stall for the next cycles
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      ledger.check_response(rsp);
    end
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      rsp_stall <= 1'b1;
      hold_cnt  <= pick_gap();
    end else begin
      rsp_stall <= 1'b0;
      hold_cnt  <= $urandom_range(0, 6);
    end
  end

  task automatic issue(input logic mode, input logic [IDX_W-1:0] index);
    req_t r;
    rsp_t want;
    int   gap;
    r.mode        = mode;
    r.freed_index = index;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    want = ledger.note_request(r);
    sent++;
    if (mode == MODE_ALLOC && want.status == ST_OK) begin
      live.push_back(want.chunk_index);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (ledger.expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need one assignment per step
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [ADDR_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ledger.write_register(idx, data);
  endtask

  task automatic configure(input logic [ADDR_W-1:0] size_word,
                           input logic [ADDR_W-1:0] base, input bit poke_unused);
    drain();
    write_register(CFG_CHUNK_BYTES, size_word);
    if (poke_unused) begin
      write_register(CFG_UNUSED_NEXT, ADDR_W'({$urandom, $urandom}));
      write_register(CFG_UNUSED_TOP, ADDR_W'({$urandom, $urandom}));
    end
    write_register(CFG_BASE_ADDRESS, base);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // mostly allocates and frees of chunks really handed out, some stray frees
  task automatic random_burst(input int count);
    int          roll;
    int unsigned pick;
    logic [IDX_W-1:0] idx;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50 || live.size() == 0) begin
        issue(MODE_ALLOC, IDX_W'($urandom));
      end else if (roll < 90) begin
        pick = $urandom_range(0, live.size() - 1);
        idx  = live[pick];
        live.delete(pick);
        issue(MODE_FREE, idx);
      end else begin
        issue(MODE_FREE, IDX_W'($urandom));
      end
    end
  endtask

  initial begin
    ledger = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset register values; fresh indices, reuse order, double free, stray free
    issue(MODE_ALLOC, '0);
    issue(MODE_ALLOC, '1);
    issue(MODE_FREE, '1);
    issue(MODE_FREE, '0);
    issue(MODE_ALLOC, '0);
    issue(MODE_ALLOC, '0);
    issue(MODE_ALLOC, '1);
    issue(MODE_FREE, 12'hAAA);
    issue(MODE_FREE, 12'h555);
    issue(MODE_FREE, 12'd2);
    issue(MODE_FREE, 12'd2);
    repeat (4) issue(MODE_ALLOC, 12'h555);
    issue(MODE_FREE, 12'd3);
    issue(MODE_ALLOC, 12'hAAA);

    // zero size, unit size with top base, largest sizes with wrapping addresses, then a random size
    configure(48'd0, 48'h1234_5678_9ABC, 1'b1);
    random_burst(70);
    configure(48'd1, '1, 1'b0);
    random_burst(70);
    calm = 1'b1;
    configure(48'd65536, 48'hFFFF_FFF0_0000, 1'b0);
    random_burst(70);
    calm = 1'b0;
    configure('1, ADDR_W'({$urandom, $urandom}), 1'b0);
    random_burst(70);
    configure(ADDR_W'($urandom_range(2, 65535)), ADDR_W'({$urandom, $urandom}), 1'b0);
    random_burst(70);

    random_burst(30);
    drain();

    $display("covered %0d requests, %0d responses checked, %0d register settings",
             sent, ledger.checked, settings);
    $display("outcomes: %0d ok, %0d exhausted, %0d frees bounced; %0d mismatches",
             ledger.ok_count, ledger.exhausted_count, ledger.rejected_count,
             ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // about 400 requests; even with every gap and stall at its longest this stays far below
  initial begin
    #5_000_000;
    $display("timeout with %0d responses outstanding", ledger.expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
